// ===== hw/rtl/obdtp_pkg.sv =====
// ----------------------------------------------------------------------------
// obdtp_pkg
// Types and constants shared by the OBD-II ISO-TP responder modules.
// ----------------------------------------------------------------------------
package obdtp_pkg;

  // input kinds carried in tuser
  localparam logic [1:0] ACT_FRAME  = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_VIN_LOW  = 2'd0;
  localparam logic [1:0] CFG_VIN_MID  = 2'd1;
  localparam logic [1:0] CFG_VIN_LAST = 2'd2;

  // obd services and pids
  localparam logic [7:0] SVC_CURRENT = 8'h01;
  localparam logic [7:0] SVC_VEHINFO = 8'h09;
  localparam logic [7:0] PID_RPM     = 8'h0C;
  localparam logic [7:0] PID_SPEED   = 8'h0D;
  localparam logic [7:0] PID_VIN     = 8'h02;
  localparam logic [7:0] RSP_OFFSET  = 8'h40;
  localparam logic [7:0] VIN_ITEMS   = 8'h01;

  // iso-tp framing
  localparam logic [3:0] PCI_SINGLE      = 4'h0;
  localparam logic [3:0] PCI_FIRST       = 4'h1;
  localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;
  localparam int         VIN_REPLY_LEN   = 20;
  localparam int         FIRST_DATA      = 6;
  localparam int         CONS_DATA       = 7;
  localparam logic [3:0] RPM_REPLY_LEN   = 4'd4;
  localparam logic [3:0] SPEED_REPLY_LEN = 4'd3;

  typedef enum logic [2:0] {
    CMD_REQ_RPM,
    CMD_REQ_SPEED,
    CMD_REQ_VIN,
    CMD_REQ_OTHER,
    CMD_TICK,
    CMD_UPDATE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] rpm;
    logic [7:0]  speed;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_REQUEST,
    PH_FLOW,
    PH_SEND
  } phase_t;

endpackage

// ===== hw/rtl/obdtp_front.sv =====
// ----------------------------------------------------------------------------
// obdtp_front
// Accepts stream requests and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module obdtp_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              q_full,
  output logic              push,
  output obdtp_pkg::cmd_t   cmd
);

  logic [7:0] b1;
  logic [7:0] b2;

  assign b1 = s_tdata[7:0];
  assign b2 = s_tdata[15:8];
  assign s_tready = !q_full;

  always_comb begin
    cmd.b1    = b1;
    cmd.b2    = b2;
    cmd.rpm   = s_tdata[31:16];
    cmd.speed = s_tdata[39:32];
    cmd.kind  = obdtp_pkg::CMD_REQ_OTHER;
    push      = s_tvalid && s_tready;
    case (s_tuser)
      obdtp_pkg::ACT_FRAME: begin
        if (b1 == obdtp_pkg::SVC_CURRENT && b2 == obdtp_pkg::PID_RPM) begin
          cmd.kind = obdtp_pkg::CMD_REQ_RPM;
        end else if (b1 == obdtp_pkg::SVC_CURRENT && b2 == obdtp_pkg::PID_SPEED) begin
          cmd.kind = obdtp_pkg::CMD_REQ_SPEED;
        end else if (b1 == obdtp_pkg::SVC_VEHINFO && b2 == obdtp_pkg::PID_VIN) begin
          cmd.kind = obdtp_pkg::CMD_REQ_VIN;
        end
      end
      obdtp_pkg::ACT_TICK:   cmd.kind = obdtp_pkg::CMD_TICK;
      obdtp_pkg::ACT_UPDATE: cmd.kind = obdtp_pkg::CMD_UPDATE;
      default: push = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/obdtp_queue.sv =====
// ----------------------------------------------------------------------------
// obdtp_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module obdtp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  obdtp_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output obdtp_pkg::cmd_t head
);

  obdtp_pkg::cmd_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full  = count == 2'd2;
  assign valid = count != 2'd0;
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/obdtp_back.sv =====
// ----------------------------------------------------------------------------
// obdtp_back
// Executes commands: builds replies, runs iso-tp pacing, holds the result.
// ----------------------------------------------------------------------------
module obdtp_back #(
  parameter int REPLY_BYTES = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  obdtp_pkg::cmd_t cmd,
  output logic            pop,
  input  logic [63:0]     vin_low,
  input  logic [63:0]     vin_mid,
  input  logic [7:0]      vin_last,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [63:0]     m_tdata
);

  localparam int RW = $clog2(REPLY_BYTES + 1);

  obdtp_pkg::phase_t phase, phase_next;
  logic [RW-1:0]     rem, rem_next;
  logic [3:0]        seq, seq_next;
  logic [7:0]        blk, blk_next;
  logic [7:0]        sep, sep_next;
  logic [7:0]        wcnt, wcnt_next;
  logic [15:0]       rpm, rpm_next;
  logic [7:0]        spd, spd_next;
  logic              out_valid, out_valid_next;
  logic [63:0]       out_data, out_data_next;
  logic [7:0]        line [REPLY_BYTES];
  logic [7:0]        line_next [REPLY_BYTES];

  logic [7:0]        vin_load [REPLY_BYTES];
  logic [159:0]      vin_flat;
  logic [RW-1:0]     cons_len;
  logic [63:0]       cons_data;
  logic [63:0]       first_data;

  assign pop      = q_valid && (!out_valid || m_tready);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign vin_flat = {vin_last, vin_mid, vin_low, obdtp_pkg::VIN_ITEMS,
                     obdtp_pkg::PID_VIN, obdtp_pkg::RSP_OFFSET | obdtp_pkg::SVC_VEHINFO};

  always_comb begin
    for (int i = 0; i < REPLY_BYTES; i++) begin
      vin_load[i] = 8'h00;
    end
    for (int i = 0; i < obdtp_pkg::VIN_REPLY_LEN; i++) begin
      vin_load[i] = vin_flat[8*i +: 8];
    end
  end

  // first frame: pci, length, six reply bytes
  always_comb begin
    first_data[7:0]  = {obdtp_pkg::PCI_FIRST, 4'h0};
    first_data[15:8] = 8'(obdtp_pkg::VIN_REPLY_LEN);
    for (int k = 0; k < obdtp_pkg::FIRST_DATA; k++) begin
      first_data[8*(k+2) +: 8] = vin_load[k];
    end
  end

  // consecutive frame: up to seven bytes from the head of the line
  always_comb begin
    cons_len = (rem < RW'(obdtp_pkg::CONS_DATA)) ? rem : RW'(obdtp_pkg::CONS_DATA);
    cons_data[7:0] = {obdtp_pkg::PCI_CONSECUTIVE, seq};
    for (int k = 0; k < obdtp_pkg::CONS_DATA; k++) begin
      cons_data[8*(k+1) +: 8] = (RW'(k) < cons_len) ? line[k] : 8'h00;
    end
  end

  always_comb begin
    phase_next     = phase;
    rem_next       = rem;
    seq_next       = seq;
    blk_next       = blk;
    sep_next       = sep;
    wcnt_next      = wcnt;
    rpm_next       = rpm;
    spd_next       = spd;
    out_valid_next = out_valid && !m_tready;
    out_data_next  = out_data;
    line_next      = line;
    if (pop) begin
      if (cmd.kind == obdtp_pkg::CMD_UPDATE) begin
        rpm_next = cmd.rpm;
        spd_next = cmd.speed;
      end else if (cmd.kind == obdtp_pkg::CMD_TICK) begin
        if (phase == obdtp_pkg::PH_SEND) begin
          if (wcnt < sep) begin
            wcnt_next = wcnt + 8'd1;
          end else begin
            wcnt_next      = 8'd0;
            out_valid_next = 1'b1;
            out_data_next  = cons_data;
            rem_next       = rem - cons_len;
            seq_next       = seq + 4'd1;
            for (int i = 0; i < REPLY_BYTES; i++) begin
              line_next[i] = (i + obdtp_pkg::CONS_DATA < REPLY_BYTES) ?
                             line[(i + obdtp_pkg::CONS_DATA) % REPLY_BYTES] : 8'h00;
            end
            if (rem_next != '0) begin
              if (blk == 8'd1) begin
                phase_next = obdtp_pkg::PH_FLOW;
              end
              if (blk != 8'd0) begin
                blk_next = blk - 8'd1;
              end
            end else begin
              phase_next = obdtp_pkg::PH_REQUEST;
            end
          end
        end
      end else begin
        case (phase)
          obdtp_pkg::PH_REQUEST: begin
            out_valid_next = 1'b1;
            out_data_next  = 64'h0;
            rem_next       = '0;
            case (cmd.kind)
              obdtp_pkg::CMD_REQ_RPM: begin
                out_data_next[39:0] = {rpm[7:0], rpm[15:8], obdtp_pkg::PID_RPM,
                                       obdtp_pkg::RSP_OFFSET | obdtp_pkg::SVC_CURRENT,
                                       obdtp_pkg::PCI_SINGLE, obdtp_pkg::RPM_REPLY_LEN};
              end
              obdtp_pkg::CMD_REQ_SPEED: begin
                out_data_next[31:0] = {spd, obdtp_pkg::PID_SPEED,
                                       obdtp_pkg::RSP_OFFSET | obdtp_pkg::SVC_CURRENT,
                                       obdtp_pkg::PCI_SINGLE, obdtp_pkg::SPEED_REPLY_LEN};
              end
              obdtp_pkg::CMD_REQ_VIN: begin
                out_data_next = first_data;
                rem_next      = RW'(obdtp_pkg::VIN_REPLY_LEN - obdtp_pkg::FIRST_DATA);
                seq_next      = 4'd1;
                phase_next    = obdtp_pkg::PH_FLOW;
                for (int i = 0; i < REPLY_BYTES; i++) begin
                  line_next[i] = (i + obdtp_pkg::FIRST_DATA < REPLY_BYTES) ?
                                 vin_load[(i + obdtp_pkg::FIRST_DATA) % REPLY_BYTES] : 8'h00;
                end
              end
              default: ;
            endcase
          end
          obdtp_pkg::PH_FLOW: begin
            blk_next   = cmd.b1;
            sep_next   = cmd.b2;
            wcnt_next  = 8'd0;
            phase_next = obdtp_pkg::PH_SEND;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= obdtp_pkg::PH_REQUEST;
      rem       <= '0;
      seq       <= 4'd1;
      blk       <= 8'd0;
      sep       <= 8'd0;
      wcnt      <= 8'd0;
      rpm       <= 16'd0;
      spd       <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      rem       <= rem_next;
      seq       <= seq_next;
      blk       <= blk_next;
      sep       <= sep_next;
      wcnt      <= wcnt_next;
      rpm       <= rpm_next;
      spd       <= spd_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
    line     <= line_next;
  end

endmodule

// ===== hw/rtl/obd_iso_tp_responder_unit.sv =====
// path: results go through the command queue, then the output register that drives m_tvalid
// throughput: one request per cycle unless the queue is full; the two-entry queue and the output
//   register let the input side take up to two more requests while a result waits on m_tready
// reset: synchronous rst clears phase, counters, values and vin registers;
//   the reply line holds no reset and is loaded by each vin request
// ----------------------------------------------------------------------------
// obd_iso_tp_responder_unit
// OBD-II responder that segments replies into iso-tp frames.
// ----------------------------------------------------------------------------
module obd_iso_tp_responder_unit #(
  parameter int REPLY_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // frame_byte1, frame_byte2, engine_rpm_value, vehicle_speed_value
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // out_byte0 .. out_byte7
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  obdtp_pkg::cmd_t push_cmd;
  obdtp_pkg::cmd_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_valid;
  logic [63:0]     vin_low;
  logic [63:0]     vin_mid;
  logic [7:0]      vin_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vin_low  <= 64'd0;
      vin_mid  <= 64'd0;
      vin_last <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        obdtp_pkg::CFG_VIN_LOW:  vin_low  <= cfg_data;
        obdtp_pkg::CFG_VIN_MID:  vin_mid  <= cfg_data;
        obdtp_pkg::CFG_VIN_LAST: vin_last <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  obdtp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  obdtp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (head)
  );

  obdtp_back #(
    .REPLY_BYTES (REPLY_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .cmd      (head),
    .pop      (pop),
    .vin_low  (vin_low),
    .vin_mid  (vin_mid),
    .vin_last (vin_last),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== hw/rtl/obdtp_checker.sv =====
// ----------------------------------------------------------------------------
// obdtp_checker
// Port-level checks on the responder's output frames.
// ----------------------------------------------------------------------------
module obdtp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // stalled frame holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output frame changed while stalled");

  // only single, first and consecutive frames
  a_pci: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:4] == obdtp_pkg::PCI_SINGLE ||
                 m_tdata[7:4] == obdtp_pkg::PCI_FIRST ||
                 m_tdata[7:4] == obdtp_pkg::PCI_CONSECUTIVE)
    else $error("bad protocol control nibble");

  // single frames carry an empty, speed or rpm reply
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:4] == obdtp_pkg::PCI_SINGLE |->
      m_tdata[3:0] == 4'd0 || m_tdata[3:0] == obdtp_pkg::SPEED_REPLY_LEN ||
      m_tdata[3:0] == obdtp_pkg::RPM_REPLY_LEN)
    else $error("bad single frame length");

  // first frame announces the vin reply
  a_first: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:4] == obdtp_pkg::PCI_FIRST |->
      m_tdata[3:0] == 4'd0 && m_tdata[15:8] == 8'(obdtp_pkg::VIN_REPLY_LEN))
    else $error("bad first frame length");

endmodule

bind obd_iso_tp_responder_unit obdtp_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the OBD-II ISO-TP responder. Requests, flow control,
// ticks and value updates go in under random bursts and gaps. Every response
// frame is checked byte by byte against a behavioral predictor of the
// responder that runs in this file.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int         REPLY_LEN    = 32;
  localparam int         SETTLE_CYC   = 8;
  localparam int         QUIET_LIMIT  = 4000;
  localparam int         ROUND_ITEMS  = 330;
  localparam logic [1:0] ACT_SPARE    = 2'd3;

  typedef logic [7:0][7:0] can_frame_t;   // element k is frame byte k

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_LIGHT,
    RX_HEAVY
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // frame_byte1, frame_byte2, engine_rpm_value, vehicle_speed_value
  logic [1:0]  s_tuser = '0;   // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // out_byte0 .. out_byte7
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // predictor state
  obdtp_pkg::phase_t tp_phase;
  logic [7:0]  reply_line [REPLY_LEN];
  int          rd_pos;
  int          bytes_left;
  logic [3:0]  seq_num;
  logic [7:0]  block_left;
  logic [7:0]  sep_ms;
  logic [7:0]  wait_cnt;
  logic [15:0] eng_rpm;
  logic [7:0]  veh_speed;
  logic [63:0] vin_low;
  logic [63:0] vin_mid;
  logic [7:0]  vin_last;

  can_frame_t  frames_due [$];
  int          mismatches = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  rx_mode_t    rx_mode = RX_STEADY;
  int          rx_span = 0;

  obd_iso_tp_responder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] vin_byte(input int k);
    if (k < 8) return vin_low[8*k +: 8];
    if (k < 16) return vin_mid[8*(k-8) +: 8];
    return vin_last;
  endfunction

  // advance the responder state by one request; returns 1 when a frame goes out
  function automatic bit next_can_frame(input logic [1:0] act, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [15:0] rpm_v,
                                        input logic [7:0] spd_v, output can_frame_t frm);
    logic [11:0] reply_len;
    int          n;
    frm = '0;
    if (act == obdtp_pkg::ACT_UPDATE) begin
      eng_rpm   = rpm_v;
      veh_speed = spd_v;
      return 1'b0;
    end
    if (act == obdtp_pkg::ACT_FRAME && tp_phase == obdtp_pkg::PH_REQUEST) begin
      reply_len     = '0;
      reply_line[0] = obdtp_pkg::RSP_OFFSET | b1;
      reply_line[1] = b2;
      if (b1 == obdtp_pkg::SVC_CURRENT && b2 == obdtp_pkg::PID_RPM) begin
        reply_line[2] = eng_rpm[15:8];
        reply_line[3] = eng_rpm[7:0];
        reply_len     = 12'(obdtp_pkg::RPM_REPLY_LEN);
      end else if (b1 == obdtp_pkg::SVC_CURRENT && b2 == obdtp_pkg::PID_SPEED) begin
        reply_line[2] = veh_speed;
        reply_len     = 12'(obdtp_pkg::SPEED_REPLY_LEN);
      end else if (b1 == obdtp_pkg::SVC_VEHINFO && b2 == obdtp_pkg::PID_VIN) begin
        reply_line[2] = obdtp_pkg::VIN_ITEMS;
        for (int k = 0; k < 17; k++) reply_line[3+k] = vin_byte(k);
        reply_len = 12'(obdtp_pkg::VIN_REPLY_LEN);
      end
      rd_pos = 0;
      if (reply_len <= obdtp_pkg::CONS_DATA) begin
        frm[0] = {obdtp_pkg::PCI_SINGLE, reply_len[3:0]};
        for (int k = 0; k < reply_len; k++) frm[1+k] = reply_line[k];
        bytes_left = 0;
        tp_phase   = obdtp_pkg::PH_REQUEST;
      end else begin
        frm[0] = {obdtp_pkg::PCI_FIRST, reply_len[11:8]};
        frm[1] = reply_len[7:0];
        for (int k = 0; k < obdtp_pkg::FIRST_DATA; k++) frm[2+k] = reply_line[k];
        rd_pos     = obdtp_pkg::FIRST_DATA;
        bytes_left = reply_len - obdtp_pkg::FIRST_DATA;
        seq_num    = 4'd1;
        tp_phase   = obdtp_pkg::PH_FLOW;
      end
      return 1'b1;
    end
    if (act == obdtp_pkg::ACT_FRAME && tp_phase == obdtp_pkg::PH_FLOW) begin
      block_left = b1;
      sep_ms     = b2;
      wait_cnt   = '0;
      tp_phase   = obdtp_pkg::PH_SEND;
      return 1'b0;
    end
    if (act == obdtp_pkg::ACT_TICK && tp_phase == obdtp_pkg::PH_SEND) begin
      if (wait_cnt < sep_ms) begin
        wait_cnt++;
        return 1'b0;
      end
      wait_cnt = '0;
      n        = bytes_left < obdtp_pkg::CONS_DATA ? bytes_left : obdtp_pkg::CONS_DATA;
      frm[0]   = {obdtp_pkg::PCI_CONSECUTIVE, seq_num};
      for (int k = 0; k < n; k++)
        if (rd_pos + k < REPLY_LEN) frm[1+k] = reply_line[rd_pos+k];
      rd_pos     += n;
      bytes_left -= n;
      seq_num    = seq_num + 4'd1;
      if (bytes_left != 0) begin
        if (block_left == 8'd1) tp_phase = obdtp_pkg::PH_FLOW;
        if (block_left != 8'd0) block_left--;
      end else begin
        tp_phase = obdtp_pkg::PH_REQUEST;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one request on the input stream, with bursts and random gaps
  task automatic send_item(input logic [1:0] act, input logic [7:0] b1, input logic [7:0] b2,
                           input logic [15:0] rpm_v, input logic [7:0] spd_v);
    can_frame_t frm;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {spd_v, rpm_v, b2, b1};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (next_can_frame(act, b1, b2, rpm_v, spd_v, frm)) frames_due.push_back(frm);
  endtask

  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 16'($urandom),
              8'($urandom));
  endtask

  task automatic wait_replies_done();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic load_vin(input logic [63:0] lo, input logic [63:0] mid,
                          input logic [7:0] last);
    logic [1:0]  idx [3];
    logic [63:0] vals [3];
    idx  = '{obdtp_pkg::CFG_VIN_LOW, obdtp_pkg::CFG_VIN_MID, obdtp_pkg::CFG_VIN_LAST};
    vals = '{lo, mid, {56'd0, last}};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    vin_low  = lo;
    vin_mid  = mid;
    vin_last = last;
  endtask

  function automatic logic [63:0] ascii_word();
    logic [63:0] w;
    for (int k = 0; k < 8; k++) w[8*k +: 8] = 8'($urandom_range(8'h30, 8'h5A));
    return w;
  endfunction

  task automatic test_reset_values();
    send_item(obdtp_pkg::ACT_FRAME, obdtp_pkg::SVC_CURRENT, obdtp_pkg::PID_RPM, '0, '0);
    send_item(obdtp_pkg::ACT_FRAME, obdtp_pkg::SVC_CURRENT, obdtp_pkg::PID_SPEED, '0, '0);
    send_item(obdtp_pkg::ACT_FRAME, obdtp_pkg::SVC_VEHINFO, obdtp_pkg::PID_VIN, '0, '0);
    send_item(obdtp_pkg::ACT_FRAME, 8'd0, 8'd0, '0, '0);
    send_item(obdtp_pkg::ACT_TICK, '0, '0, '0, '0);
    send_item(obdtp_pkg::ACT_TICK, '0, '0, '0, '0);
  endtask

  task automatic test_single_frames();
    send_item(obdtp_pkg::ACT_UPDATE, '0, '0, 16'hFFFF, 8'hFF);
    send_item(obdtp_pkg::ACT_FRAME, obdtp_pkg::SVC_CURRENT, obdtp_pkg::PID_RPM, '0, '0);
    send_item(obdtp_pkg::ACT_FRAME, obdtp_pkg::SVC_CURRENT, obdtp_pkg::PID_SPEED, '0, '0);
    send_item(obdtp_pkg::ACT_FRAME, 8'hFF, 8'hFF, '0, '0);
    send_item(obdtp_pkg::ACT_FRAME, obdtp_pkg::SVC_CURRENT, 8'h00, '0, '0);
  endtask

  task automatic test_flow_control();
    send_item(obdtp_pkg::ACT_TICK, '0, '0, '0, '0);
    send_item(ACT_SPARE, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(obdtp_pkg::ACT_FRAME, obdtp_pkg::SVC_VEHINFO, obdtp_pkg::PID_VIN, '0, '0);
    send_item(obdtp_pkg::ACT_TICK, '0, '0, '0, '0);
    send_item(obdtp_pkg::ACT_FRAME, 8'd1, 8'd2, '0, '0);
    send_item(obdtp_pkg::ACT_FRAME, obdtp_pkg::SVC_CURRENT, obdtp_pkg::PID_RPM, '0, '0);
    send_item(obdtp_pkg::ACT_UPDATE, '0, '0, 16'h1234, 8'h56);
    send_item(obdtp_pkg::ACT_TICK, '0, '0, '0, '0);
    send_item(obdtp_pkg::ACT_TICK, '0, '0, '0, '0);
    send_item(obdtp_pkg::ACT_TICK, '0, '0, '0, '0);
    send_item(obdtp_pkg::ACT_FRAME, 8'hFF, 8'd1, '0, '0);
    send_item(obdtp_pkg::ACT_TICK, '0, '0, '0, '0);
    send_item(obdtp_pkg::ACT_TICK, '0, '0, '0, '0);
    send_item(obdtp_pkg::ACT_FRAME, obdtp_pkg::SVC_CURRENT, obdtp_pkg::PID_RPM, '0, '0);
  endtask

  task automatic test_random_traffic();
    int useful;
    int pick;
    for (int round = 0; round < 4; round++) begin
      wait_replies_done();
      case (round)
        0:       load_vin(ascii_word(), ascii_word(), 8'($urandom_range(8'h30, 8'h5A)));
        1:       load_vin('0, '0, '0);
        default: load_vin({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
      endcase
      useful = 0;
      while (useful < ROUND_ITEMS) begin
        pick = $urandom_range(0, 19);
        if (tp_phase == obdtp_pkg::PH_REQUEST && pick < 14) begin
          case ($urandom_range(0, 5))
            0, 1, 2: send_item(obdtp_pkg::ACT_FRAME, obdtp_pkg::SVC_VEHINFO,
                               obdtp_pkg::PID_VIN, '0, '0);
            3:       send_item(obdtp_pkg::ACT_FRAME, obdtp_pkg::SVC_CURRENT,
                               obdtp_pkg::PID_RPM, '0, '0);
            4:       send_item(obdtp_pkg::ACT_FRAME, obdtp_pkg::SVC_CURRENT,
                               obdtp_pkg::PID_SPEED, '0, '0);
            default: send_item(obdtp_pkg::ACT_FRAME, 8'($urandom), 8'($urandom), '0, '0);
          endcase
          useful++;
        end else if (tp_phase == obdtp_pkg::PH_REQUEST && pick < 17) begin
          send_item(obdtp_pkg::ACT_UPDATE, 8'($urandom), 8'($urandom), 16'($urandom),
                    8'($urandom));
          useful++;
        end else if (tp_phase == obdtp_pkg::PH_FLOW && pick < 16) begin
          send_item(obdtp_pkg::ACT_FRAME,
                    $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2)),
                    $urandom_range(0, 39) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3)),
                    16'($urandom), 8'($urandom));
          useful++;
        end else if (tp_phase == obdtp_pkg::PH_SEND && pick < 16) begin
          send_item(obdtp_pkg::ACT_TICK, 8'($urandom), 8'($urandom), 16'($urandom),
                    8'($urandom));
          useful++;
        end else begin
          send_noise();
        end
      end
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_span <= $urandom_range(8, 80);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      RX_STEADY: m_tready <= 1'b1;
      RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
      default:   m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // response check
  always @(posedge clk) begin
    can_frame_t want;
    can_frame_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected frame %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        for (int k = 0; k < 8; k++)
          if (got[k] !== want[k]) begin
            $display("%0t: out_byte%0d expected %h actual %h", $time, k, want[k], got[k]);
            mismatches++;
          end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, %0d frames outstanding", $time, frames_due.size());
      $display("obd_iso_tp_responder_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tp_phase   = obdtp_pkg::PH_REQUEST;
    rd_pos     = 0;
    bytes_left = 0;
    seq_num    = 4'd1;
    block_left = '0;
    sep_ms     = '0;
    wait_cnt   = '0;
    eng_rpm    = '0;
    veh_speed  = '0;
    vin_low    = '0;
    vin_mid    = '0;
    vin_last   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_single_frames();
    wait_replies_done();
    load_vin('1, '1, 8'hFF);
    test_flow_control();
    test_random_traffic();
    wait_replies_done();
    if (mismatches == 0) begin
      $display("obd_iso_tp_responder_unit verification clean");
    end else begin
      $display("obd_iso_tp_responder_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== obd_iso_tp_responder_unit.f =====
hw/rtl/obdtp_pkg.sv
hw/rtl/obdtp_front.sv
hw/rtl/obdtp_queue.sv
hw/rtl/obdtp_back.sv
hw/rtl/obd_iso_tp_responder_unit.sv
hw/rtl/obdtp_checker.sv
test/tb_top.sv
